[hw/rtl/msc_pkg.sv]
package msc_pkg;

    localparam int MEM_WORDS = 16384;

    typedef enum logic [1:0] {
        CMD_LOAD_MEM = 2'd0,
        CMD_WRITE_REG = 2'd1,
        CMD_SET_PC = 2'd2,
        CMD_STEP = 2'd3
    } cmd_t;

    localparam logic [1:0] CLASS_R = 2'd0;
    localparam logic [1:0] CLASS_I = 2'd1;
    localparam logic [1:0] CLASS_J = 2'd2;
    localparam logic [1:0] CLASS_NONE = 2'd3;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J = 6'h02;
    localparam logic [5:0] OP_JAL = 6'h03;
    localparam logic [5:0] OP_BEQ = 6'h04;
    localparam logic [5:0] OP_BNE = 6'h05;
    localparam logic [5:0] OP_ADDI = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI = 6'h0a;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI = 6'h0c;
    localparam logic [5:0] OP_ORI = 6'h0d;
    localparam logic [5:0] OP_LUI = 6'h0f;
    localparam logic [5:0] OP_LW = 6'h23;
    localparam logic [5:0] OP_SW = 6'h2b;

    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_JR = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR = 6'h25;
    localparam logic [5:0] FN_NOR = 6'h27;
    localparam logic [5:0] FN_SLT = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] instruction;
        logic [1:0]  inst_class;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] write_value;
        logic        mem_written;
        logic        mem_read;
        logic [13:0] mem_word;
        logic        branch_taken;
        logic        illegal;
    } result_t;

    // Decoded instruction fields and control produced by the execute stage.
    typedef struct packed {
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] res;
        logic        is_load;
        logic        is_store;
        logic [31:0] addr;
        logic [31:0] npc;
        logic        taken;
        logic        ill;
        logic [1:0]  cls;
    } exec_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic lt_signed(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

[hw/rtl/mips_single_cycle_core.sv]
// One transaction is handled at a time. It is accepted in the idle cycle, then
// passes through instruction fetch from the word memory, register read with
// execute and data memory access, and register writeback; each phase needs one
// synchronous access to the word memory or register file. The result is
// registered at writeback and the next transaction can be accepted once the
// core is back in idle. Non-step commands also pass through the same phases.
// Input is accepted while a result still waits to be taken; writeback holds
// until that result leaves the output register. Memory words that were never
// written read as undefined; the register file and PC reset to zero.
module mips_single_cycle_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [13:0] word_index,
    input  logic [4:0]  reg_index,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic [31:0] instruction,
    output logic [1:0]  inst_class,
    output logic        reg_written,
    output logic [4:0]  dest_reg,
    output logic [31:0] write_value,
    output logic        mem_written,
    output logic        mem_read,
    output logic [13:0] mem_word,
    output logic        branch_taken,
    output logic        illegal
);
    import msc_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FETCH = 4'b0010,
        S_EXEC = 4'b0100,
        S_WB = 4'b1000
    } state_t;

    state_t      state_reg;
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rf [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] pc_reg;
    logic [31:0] mem_q_reg;
    logic [31:0] rfa_q_reg;
    logic [31:0] rfb_q_reg;
    logic [1:0]  cmd_reg;
    logic [13:0] widx_reg;
    logic [4:0]  ridx_reg;
    logic [31:0] val_reg;
    logic [31:0] inst_reg;
    exec_t       ex;
    exec_t       ex_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        out_valid_reg;
    logic        wb_go;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0] a_val;
    logic [31:0] b_val;
    logic [31:0] wb_val;
    logic        rf_we;
    logic [AW+1:0] pc_slot;
    logic [AW+1:0] ld_slot;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign wb_go = (state_reg == S_WB) && (!out_valid_reg || out_ready);

    assign pc_slot = pc_reg[AW+1:0];
    assign ld_slot = ex.addr[AW+1:0];

    // Fetch reads at the PC; the execute phase reads at the load address.
    always_comb
    begin
        mem_raddr = pc_slot[AW+1:2];
        if (state_reg == S_EXEC)
            mem_raddr = ld_slot[AW+1:2];
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = {AW{1'b0}};
        mem_wdata = val_reg;
        if (state_reg == S_FETCH && cmd_reg == CMD_LOAD_MEM)
        begin
            mem_we = 1'b1;
            mem_waddr = AW'({18'd0, widx_reg} % MEM_WORDS);
        end
        else if (state_reg == S_EXEC && cmd_reg == CMD_STEP && ex.is_store)
        begin
            mem_we = 1'b1;
            mem_waddr = ex.addr[AW+1:2];
            mem_wdata = b_val;
        end
    end

    // The read data is held during writeback so a load result survives a stall.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg != S_WB)
            mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[res_next.dest_reg] <= res_next.write_value;
        rfa_q_reg <= rf[mem_q_reg[25:21]];
        rfb_q_reg <= rf[mem_q_reg[20:16]];
    end

    // Valid bits make never-written registers read as zero after reset.
    assign a_val = rf_valid_reg[inst_reg[25:21]] ? rfa_q_reg : 32'd0;
    assign b_val = rf_valid_reg[inst_reg[20:16]] ? rfb_q_reg : 32'd0;

    msc_exec u_exec (
        .pc(pc_reg),
        .inst(inst_reg),
        .a(a_val),
        .b(b_val),
        .ex(ex)
    );

    assign wb_val = ex_reg.is_load ? mem_q_reg : ex_reg.res;

    always_comb
    begin
        res_next = '0;
        res_next.next_pc = pc_reg;
        res_next.inst_class = CLASS_NONE;
        rf_we = 1'b0;
        unique case (cmd_reg)
            CMD_WRITE_REG:
            begin
                if (ridx_reg != 5'd0)
                begin
                    res_next.reg_written = 1'b1;
                    res_next.dest_reg = ridx_reg;
                    res_next.write_value = val_reg;
                end
            end
            CMD_SET_PC: res_next.next_pc = val_reg;
            CMD_STEP:
            begin
                res_next.next_pc = ex_reg.npc;
                res_next.instruction = inst_reg;
                res_next.inst_class = ex_reg.cls;
                res_next.mem_written = ex_reg.is_store;
                res_next.mem_read = ex_reg.is_load;
                res_next.mem_word = (ex_reg.is_load || ex_reg.is_store)
                    ? 14'(ex_reg.addr[AW+1:2]) : 14'd0;
                res_next.branch_taken = ex_reg.taken;
                res_next.illegal = ex_reg.ill;
                if (ex_reg.wr && ex_reg.dst != 5'd0)
                begin
                    res_next.reg_written = 1'b1;
                    res_next.dest_reg = ex_reg.dst;
                    res_next.write_value = wb_val;
                end
            end
            default: ;
        endcase
        if (wb_go)
            rf_we = res_next.reg_written;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            pc_reg <= 32'd0;
            rf_valid_reg <= 32'd0;
        end
        else
        begin
            if (wb_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                        state_reg <= S_FETCH;
                S_FETCH: state_reg <= S_EXEC;
                S_EXEC: state_reg <= S_WB;
                S_WB:
                begin
                    if (wb_go)
                    begin
                        state_reg <= S_IDLE;
                        pc_reg <= res_next.next_pc;
                        if (rf_we)
                            rf_valid_reg[res_next.dest_reg] <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= opcode;
            widx_reg <= word_index;
            ridx_reg <= reg_index;
            val_reg <= value;
        end
        if (state_reg == S_FETCH)
            inst_reg <= mem_q_reg;
        if (state_reg == S_EXEC)
            ex_reg <= ex;
        if (wb_go)
            res_reg <= res_next;
    end

    assign next_pc = res_reg.next_pc;
    assign instruction = res_reg.instruction;
    assign inst_class = res_reg.inst_class;
    assign reg_written = res_reg.reg_written;
    assign dest_reg = res_reg.dest_reg;
    assign write_value = res_reg.write_value;
    assign mem_written = res_reg.mem_written;
    assign mem_read = res_reg.mem_read;
    assign mem_word = res_reg.mem_word;
    assign branch_taken = res_reg.branch_taken;
    assign illegal = res_reg.illegal;

endmodule

[hw/rtl/msc_exec.sv]
module msc_exec (
    input  logic [31:0] pc,
    input  logic [31:0] inst,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output msc_pkg::exec_t ex
);
    import msc_pkg::*;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] jtarget;

    assign op = inst[31:26];
    assign fn = inst[5:0];
    assign sh = inst[10:6];
    assign imm = inst[15:0];
    assign simm = sext16(imm);
    assign pc4 = pc + 32'd4;
    assign jtarget = {pc4[31:28], inst[25:0], 2'b00};

    always_comb
    begin
        ex = '0;
        ex.npc = pc4;
        ex.addr = a + simm;
        ex.cls = (op == OP_RTYPE) ? CLASS_R
               : ((op == OP_J || op == OP_JAL) ? CLASS_J : CLASS_I);
        unique case (op)
            OP_RTYPE:
            begin
                ex.wr = 1'b1;
                ex.dst = inst[15:11];
                unique case (fn)
                    FN_AND: ex.res = a & b;
                    FN_OR: ex.res = a | b;
                    FN_NOR: ex.res = ~(a | b);
                    FN_SLL: ex.res = b << sh;
                    FN_SRL: ex.res = b >> sh;
                    FN_ADD, FN_ADDU: ex.res = a + b;
                    FN_SUB, FN_SUBU: ex.res = a - b;
                    FN_SLT, FN_SLTU: ex.res = {31'd0, lt_signed(a, b)};
                    FN_JR:
                    begin
                        ex.wr = 1'b0;
                        ex.npc = a;
                    end
                    FN_JALR:
                    begin
                        ex.dst = LINK_REG;
                        ex.res = pc4 + 32'd4;
                        ex.npc = a;
                    end
                    default:
                    begin
                        ex.wr = 1'b0;
                        ex.ill = 1'b1;
                    end
                endcase
            end
            OP_J: ex.npc = jtarget;
            OP_JAL:
            begin
                ex.npc = jtarget;
                ex.wr = 1'b1;
                ex.dst = LINK_REG;
                ex.res = pc4 + 32'd4;
            end
            OP_BEQ, OP_BNE:
            begin
                if ((a == b) == (op == OP_BEQ))
                begin
                    ex.taken = 1'b1;
                    ex.npc = pc4 + {simm[29:0], 2'b00};
                end
            end
            OP_ADDI, OP_ADDIU:
            begin
                ex.wr = 1'b1;
                ex.dst = inst[20:16];
                ex.res = a + simm;
            end
            OP_SLTI, OP_SLTIU:
            begin
                ex.wr = 1'b1;
                ex.dst = inst[20:16];
                ex.res = {31'd0, lt_signed(a, simm)};
            end
            OP_ANDI:
            begin
                ex.wr = 1'b1;
                ex.dst = inst[20:16];
                ex.res = a & {16'd0, imm};
            end
            OP_ORI:
            begin
                ex.wr = 1'b1;
                ex.dst = inst[20:16];
                ex.res = a | {16'd0, imm};
            end
            OP_LUI:
            begin
                ex.wr = 1'b1;
                ex.dst = inst[20:16];
                ex.res = {imm, 16'd0};
            end
            OP_LW:
            begin
                ex.wr = 1'b1;
                ex.dst = inst[20:16];
                ex.is_load = 1'b1;
            end
            OP_SW: ex.is_store = 1'b1;
            default: ex.ill = 1'b1;
        endcase
    end

endmodule

[test/mips_single_cycle_core_tb.sv]
`timescale 1ns / 100ps

module mips_single_cycle_core_tb;
    import msc_pkg::*;

    localparam int WORDS = 16384;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 2000;

    class core_scoreboard;
        logic [31:0] mem [WORDS];
        bit          loaded [WORDS];
        logic [31:0] regs [32];
        logic [31:0] pc;
        result_t     expected_q [$];
        int          errors;

        function new();
            for (int i = 0; i < 32; i++)
            begin
                regs[i] = '0;
            end
            pc = '0;
            errors = 0;
        endfunction

        // Updates the core state for one accepted transaction and queues its result.
        function void note_input(cmd_t cmd, logic [13:0] widx, logic [4:0] ridx,
                                 logic [31:0] val);
            result_t r;
            logic [31:0] inst, a, b, pc4, npc, res, addr;
            logic [5:0]  op, fn;
            logic [4:0]  rs, rt, rd, sh, dst;
            logic [13:0] slot;
            bit wr;
            r = '0;
            r.inst_class = CLASS_NONE;
            case (cmd)
                CMD_LOAD_MEM:
                begin
                    mem[widx] = val;
                    loaded[widx] = 1;
                end
                CMD_WRITE_REG:
                begin
                    if (ridx != 0)
                    begin
                        regs[ridx] = val;
                        r.reg_written = 1;
                        r.dest_reg = ridx;
                        r.write_value = val;
                    end
                end
                CMD_SET_PC: pc = val;
                default:
                begin
                    pc4 = pc + 32'd4;
                    npc = pc4;
                    inst = mem[pc[15:2]];
                    op = inst[31:26];
                    rs = inst[25:21];
                    rt = inst[20:16];
                    rd = inst[15:11];
                    sh = inst[10:6];
                    fn = inst[5:0];
                    a = regs[rs];
                    b = regs[rt];
                    wr = 0;
                    dst = '0;
                    res = '0;
                    r.instruction = inst;
                    r.inst_class = (op == OP_RTYPE) ? CLASS_R :
                                   ((op == OP_J || op == OP_JAL) ? CLASS_J : CLASS_I);
                    case (op)
                        OP_RTYPE:
                        begin
                            wr = 1;
                            dst = rd;
                            case (fn)
                                FN_AND: res = a & b;
                                FN_OR: res = a | b;
                                FN_NOR: res = ~(a | b);
                                FN_SLL: res = b << sh;
                                FN_SRL: res = b >> sh;
                                FN_ADD, FN_ADDU: res = a + b;
                                FN_SUB, FN_SUBU: res = a - b;
                                FN_SLT, FN_SLTU: res = {31'd0, $signed(a) < $signed(b)};
                                FN_JR:
                                begin
                                    wr = 0;
                                    npc = a;
                                end
                                FN_JALR:
                                begin
                                    dst = LINK_REG;
                                    res = pc4 + 32'd4;
                                    npc = a;
                                end
                                default:
                                begin
                                    wr = 0;
                                    r.illegal = 1;
                                end
                            endcase
                        end
                        OP_J: npc = {pc4[31:28], inst[25:0], 2'b00};
                        OP_JAL:
                        begin
                            npc = {pc4[31:28], inst[25:0], 2'b00};
                            wr = 1;
                            dst = LINK_REG;
                            res = pc4 + 32'd4;
                        end
                        OP_BEQ, OP_BNE:
                        begin
                            if ((a == b) == (op == OP_BEQ))
                            begin
                                r.branch_taken = 1;
                                npc = pc4 + {{14{inst[15]}}, inst[15:0], 2'b00};
                            end
                        end
                        OP_ADDI, OP_ADDIU:
                        begin
                            wr = 1;
                            dst = rt;
                            res = a + {{16{inst[15]}}, inst[15:0]};
                        end
                        OP_SLTI, OP_SLTIU:
                        begin
                            wr = 1;
                            dst = rt;
                            res = {31'd0, $signed(a) < $signed({{16{inst[15]}}, inst[15:0]})};
                        end
                        OP_ANDI:
                        begin
                            wr = 1;
                            dst = rt;
                            res = a & {16'd0, inst[15:0]};
                        end
                        OP_ORI:
                        begin
                            wr = 1;
                            dst = rt;
                            res = a | {16'd0, inst[15:0]};
                        end
                        OP_LUI:
                        begin
                            wr = 1;
                            dst = rt;
                            res = {inst[15:0], 16'd0};
                        end
                        OP_LW:
                        begin
                            addr = a + {{16{inst[15]}}, inst[15:0]};
                            slot = addr[15:2];
                            r.mem_read = 1;
                            r.mem_word = slot;
                            wr = 1;
                            dst = rt;
                            res = mem[slot];
                        end
                        OP_SW:
                        begin
                            addr = a + {{16{inst[15]}}, inst[15:0]};
                            slot = addr[15:2];
                            r.mem_written = 1;
                            r.mem_word = slot;
                            mem[slot] = b;
                            loaded[slot] = 1;
                        end
                        default: r.illegal = 1;
                    endcase
                    if (wr && dst != 0)
                    begin
                        regs[dst] = res;
                        r.reg_written = 1;
                        r.dest_reg = dst;
                        r.write_value = res;
                    end
                    pc = npc;
                end
            endcase
            r.next_pc = pc;
            expected_q.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v)
            begin
                $error("%s: expected %h, got %h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result arrived with no transaction outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare("next_pc", e.next_pc, got.next_pc);
            compare("instruction", e.instruction, got.instruction);
            compare("inst_class", e.inst_class, got.inst_class);
            compare("reg_written", e.reg_written, got.reg_written);
            compare("dest_reg", e.dest_reg, got.dest_reg);
            compare("write_value", e.write_value, got.write_value);
            compare("mem_written", e.mem_written, got.mem_written);
            compare("mem_read", e.mem_read, got.mem_read);
            compare("mem_word", e.mem_word, got.mem_word);
            compare("branch_taken", e.branch_taken, got.branch_taken);
            compare("illegal", e.illegal, got.illegal);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [13:0] word_index;
    logic [4:0]  reg_index;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] next_pc;
    logic [31:0] instruction;
    logic [1:0]  inst_class;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic        mem_written;
    logic        mem_read;
    logic [13:0] mem_word;
    logic        branch_taken;
    logic        illegal;

    core_scoreboard sb;
    bit burst;
    int idle_cycles;

    mips_single_cycle_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .word_index(word_index), .reg_index(reg_index), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_pc(next_pc), .instruction(instruction), .inst_class(inst_class),
        .reg_written(reg_written), .dest_reg(dest_reg), .write_value(write_value),
        .mem_written(mem_written), .mem_read(mem_read), .mem_word(mem_word),
        .branch_taken(branch_taken), .illegal(illegal)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [4:0] sh, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [5:0] fn_list [13] = '{FN_SLL, FN_SRL, FN_JR, FN_JALR, FN_ADD, FN_ADDU,
            FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU};
        logic [5:0] op_list [13] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU,
            OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW};
        logic [31:0] w;
        int pick;
        w = $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            w[5:0] = fn_list[$urandom_range(0, 12)];
        if (pick < 9)
            w[31:26] = OP_RTYPE;
        else if (pick < 19)
        begin
            w[31:26] = op_list[$urandom_range(0, 12)];
            // Short branches keep the program in a small area most of the time.
            if (w[31:26] == OP_BEQ || w[31:26] == OP_BNE)
                if ($urandom_range(0, 3) != 0)
                    w[15:0] = 16'($signed($urandom_range(0, 16)) - 8);
        end
        return w;
    endfunction

    task automatic send(cmd_t cmd, logic [13:0] widx, logic [4:0] ridx, logic [31:0] val);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= cmd;
        word_index <= widx;
        reg_index <= ridx;
        value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(cmd, widx, ridx, val);
    endtask

    // Steps once, first loading any word the step would read that was never written.
    task automatic step_once();
        logic [31:0] inst, addr;
        logic [13:0] slot;
        slot = sb.pc[15:2];
        if (!sb.loaded[slot])
            send(CMD_LOAD_MEM, slot, 5'($urandom), random_instruction());
        inst = sb.mem[slot];
        if (inst[31:26] == OP_LW)
        begin
            addr = sb.regs[inst[25:21]] + {{16{inst[15]}}, inst[15:0]};
            if (!sb.loaded[addr[15:2]])
                send(CMD_LOAD_MEM, addr[15:2], 5'($urandom), $urandom);
        end
        send(CMD_STEP, 14'($urandom), 5'($urandom), $urandom);
    endtask

    task automatic run_instr(logic [31:0] inst);
        send(CMD_LOAD_MEM, sb.pc[15:2], 5'd0, inst);
        step_once();
    endtask

    always
    begin
        int gap;
        @(negedge clk);
        gap = burst ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            out_ready <= 1'b0;
            @(negedge clk);
        end
        out_ready <= 1'b1;
        do
            @(posedge clk);
        while (!(out_valid && rst_n));
        sb.check_result('{next_pc, instruction, inst_class, reg_written, dest_reg,
            write_value, mem_written, mem_read, mem_word, branch_taken, illegal});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int pick;
        sb = new();
        burst = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = CMD_LOAD_MEM;
        word_index = '0;
        reg_index = '0;
        value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(CMD_WRITE_REG, 14'h3fff, 5'd0, 32'hffffffff);
        send(CMD_WRITE_REG, 14'd0, 5'd1, 32'hffffffff);
        send(CMD_WRITE_REG, 14'd0, 5'd2, 32'h80000000);
        send(CMD_WRITE_REG, 14'd0, 5'd3, 32'd1);
        send(CMD_LOAD_MEM, 14'h3fff, 5'd31, enc_r(5'd1, 5'd3, 5'd4, 5'd0, FN_ADD));
        send(CMD_SET_PC, 14'd0, 5'd0, 32'hfffffffd);
        step_once();
        run_instr(enc_r(5'd2, 5'd3, 5'd5, 5'd0, FN_SUBU));
        run_instr(enc_r(5'd2, 5'd3, 5'd6, 5'd0, FN_SLTU));
        run_instr(enc_r(5'd1, 5'd2, 5'd7, 5'd31, FN_SRL));
        run_instr(enc_r(5'd1, 5'd3, 5'd8, 5'd31, FN_SLL));
        run_instr(enc_r(5'd2, 5'd3, 5'd0, 5'd0, FN_NOR));
        run_instr(enc_i(OP_ADDI, 5'd3, 5'd9, 16'h8000));
        run_instr(enc_i(OP_SLTIU, 5'd3, 5'd10, 16'hffff));
        run_instr(enc_i(OP_LUI, 5'd0, 5'd11, 16'hffff));
        run_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'hfffc));
        run_instr(enc_i(OP_LW, 5'd0, 5'd12, 16'hfffc));
        run_instr(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hffff));
        run_instr(enc_r(5'd2, 5'd0, 5'd0, 5'd0, FN_JALR));
        run_instr({OP_JAL, 26'h3ffffff});
        run_instr({6'h3f, 26'h0});
        run_instr(enc_r(5'd0, 5'd0, 5'd13, 5'd0, 6'h3f));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 0)
                burst = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                step_once();
            else if (pick < 78)
                send(CMD_LOAD_MEM, 14'($urandom), 5'($urandom),
                     ($urandom_range(0, 1) == 1) ? random_instruction() : $urandom);
            else if (pick < 93)
                send(CMD_WRITE_REG, 14'($urandom), 5'($urandom),
                     ($urandom_range(0, 1) == 1) ? $urandom_range(0, 64) : $urandom);
            else
                send(CMD_SET_PC, 14'($urandom), 5'($urandom),
                     ($urandom_range(0, 1) == 1) ? $urandom_range(0, 255) : $urandom);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/msc_pkg.sv
hw/rtl/msc_exec.sv
hw/rtl/mips_single_cycle_core.sv
test/mips_single_cycle_core_tb.sv
